### rtl/sed_pkg.sv
// Shared types and constants for the string escape decoder.
// Channel payload structs, escape phase codes and character codes.
// No dependencies.
package sed_pkg;

	localparam int ByteW     = 8;
	localparam int PhaseW    = 3;
	localparam int CountW    = 3;
	localparam int AccW      = 24;
	localparam int PendDepth = 7;
	localparam int BurstMax  = 8;
	localparam int BurstIdxW = 3;
	localparam int BurstCntW = 4;

	// Escape phase codes
	localparam logic [PhaseW-1:0] PH_PLAIN = 3'd0;
	localparam logic [PhaseW-1:0] PH_ESC   = 3'd1;
	localparam logic [PhaseW-1:0] PH_X1    = 3'd2;
	localparam logic [PhaseW-1:0] PH_X2    = 3'd3;
	localparam logic [PhaseW-1:0] PH_USIGN = 3'd4;
	localparam logic [PhaseW-1:0] PH_UDIG  = 3'd5;

	// Character codes
	localparam logic [ByteW-1:0] CH_BSLASH = 8'h5c;
	localparam logic [ByteW-1:0] CH_N      = 8'h6e;
	localparam logic [ByteW-1:0] CH_R      = 8'h72;
	localparam logic [ByteW-1:0] CH_T      = 8'h74;
	localparam logic [ByteW-1:0] CH_X      = 8'h78;
	localparam logic [ByteW-1:0] CH_U      = 8'h75;
	localparam logic [ByteW-1:0] CH_PLUS   = 8'h2b;
	localparam logic [ByteW-1:0] CH_MINUS  = 8'h2d;
	localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
	localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
	localparam logic [ByteW-1:0] CH_LF     = 8'h0a;
	localparam logic [ByteW-1:0] CH_CR     = 8'h0d;
	localparam logic [ByteW-1:0] CH_TAB    = 8'h09;

	// UTF-8 constants
	localparam logic [AccW-1:0]  REPLACEMENT = 24'h00fffd;
	localparam logic [AccW-1:0]  LIM_1B      = 24'h00007f;
	localparam logic [AccW-1:0]  LIM_2B      = 24'h0007ff;
	localparam logic [AccW-1:0]  LIM_3B      = 24'h00ffff;
	localparam logic [ByteW-1:0] LEAD_2B     = 8'hc0;
	localparam logic [ByteW-1:0] LEAD_3B     = 8'he0;
	localparam logic [ByteW-1:0] LEAD_4B     = 8'hf0;
	localparam logic [ByteW-1:0] CONT_MARK   = 8'h80;
	localparam logic [5:0]       CONT_MASK   = 6'h3f;

	typedef struct packed {
		logic [ByteW-1:0] in_byte;
		logic             in_last;
		logic             quoted;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             out_valid;
		logic             out_last;
		logic             trailing_backslash_error;
		logic             seen_single_quote;
		logic             seen_double_quote;
		logic             seen_both_quotes;
	} out_item_t;

	typedef struct packed {
		logic escape_enable;
	} cfg_item_t;

endpackage

### rtl/sed_chan_if.sv
// Valid/ready channel carrying one payload of a chosen type.
// Used for the input, result and configuration channels; no dependencies.
interface sed_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/string_escape_utf8_decoder_core.sv
// Backslash escape decoder for string token bodies, producing UTF-8 bytes.
// Depends on sed_pkg and sed_chan_if.
//
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+------------------
//  in_ch    | in  | in_byte, in_last, quoted                  | valid & ready
//  out_ch   | out | out_byte, out_valid, out_last, flags      | valid & ready
//  cfg_ch   | in  | escape_enable                             | valid & ready
//
// An input byte is registered, decoded combinationally into a burst of 0 to 7
// result bytes, and the burst register drains one result per cycle while out_ch
// is ready. A byte that yields one result sustains one byte per cycle without a
// stall; a byte with N results holds back the next byte while its burst drains.
// Reset clears the escape state, quote flags and valid bits; escape_enable
// resets to 1. A stalled result holds while the next byte waits in the input
// register.
module string_escape_utf8_decoder_core (
	input logic      clk,
	input logic      arst_n,
	sed_chan_if.sink   in_ch,
	sed_chan_if.source out_ch,
	sed_chan_if.sink   cfg_ch
);
	import sed_pkg::*;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]            n;
		logic [3:0][ByteW-1:0] b;
	} utf8_t;

	function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) r.val = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) r.val = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) r.val = 4'(c - 8'h37);
		else r.ok = 1'b0;
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [AccW-1:0] w);
		utf8_t r;
		r.b = '0;
		if (w <= LIM_1B) begin
			r.n    = 3'd1;
			r.b[0] = w[7:0];
		end else if (w <= LIM_2B) begin
			r.n    = 3'd2;
			r.b[0] = LEAD_2B | {3'b0, w[10:6]};
			r.b[1] = CONT_MARK | {2'b0, w[5:0] & CONT_MASK};
		end else if (w <= LIM_3B) begin
			r.n    = 3'd3;
			r.b[0] = LEAD_3B | {4'b0, w[15:12]};
			r.b[1] = CONT_MARK | {2'b0, w[11:6]};
			r.b[2] = CONT_MARK | {2'b0, w[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = LEAD_4B | {5'b0, w[20:18]};
			r.b[1] = CONT_MARK | {2'b0, w[17:12]};
			r.b[2] = CONT_MARK | {2'b0, w[11:6]};
			r.b[3] = CONT_MARK | {2'b0, w[5:0]};
		end
		return r;
	endfunction

	// Configuration and token state
	logic              esc_en_q;
	logic [PhaseW-1:0] phase_q;
	logic [CountW-1:0] dc_q;
	logic [AccW-1:0]   acc_q;
	logic              wide_q;
	logic              dv_q;
	logic [1:0]        quote_q;
	logic [ByteW-1:0]  pend_q [PendDepth];

	// Input register
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;
	logic             quoted_s1;

	// Burst register
	logic                 valid_s2;
	logic [ByteW-1:0]     bytes_s2 [BurstMax];
	logic [BurstCntW-1:0] cnt_s2;
	logic [BurstCntW-1:0] nres_s2;
	logic [BurstIdxW-1:0] idx_q;
	logic                 last_s2;
	logic                 err_s2;
	logic [1:0]           quote_s2;

	// Decode results
	logic [ByteW-1:0]     b_n [BurstMax];
	logic [BurstCntW-1:0] cnt_n;
	logic                 err_n;
	logic [PhaseW-1:0]    phase_n;
	logic [CountW-1:0]    dc_n;
	logic [AccW-1:0]      acc_n;
	logic                 wide_n;
	logic                 dv_n;
	logic                 pend_we;
	logic [1:0]           quote_n;
	hex_t                 hx;
	utf8_t                enc;
	logic [CountW-1:0]    dc_inc;
	logic                 dv_upd;
	logic [AccW-1:0]      acc_upd;
	logic [CountW-1:0]    need;

	logic out_xfer, burst_done, s2_free, commit;

	assign out_xfer   = valid_s2 && out_ch.ready;
	assign burst_done = out_xfer && ({1'b0, idx_q} == nres_s2 - BurstCntW'(1));
	assign s2_free    = !valid_s2 || burst_done;
	assign commit     = valid_s1 && s2_free;

	assign in_ch.ready  = !valid_s1 || s2_free;
	assign cfg_ch.ready = 1'b1;

	// Decode the registered byte against the escape state
	always_comb begin
		for (int i = 0; i < BurstMax; i++) b_n[i] = '0;
		cnt_n   = '0;
		err_n   = 1'b0;
		phase_n = PH_PLAIN;
		dc_n    = dc_q;
		acc_n   = acc_q;
		wide_n  = wide_q;
		dv_n    = dv_q;
		pend_we = 1'b0;
		hx      = hex_decode(byte_s1);
		dc_inc  = dc_q + CountW'(1);
		dv_upd  = dv_q && hx.ok;
		acc_upd = hx.ok ? {acc_q[AccW-5:0], hx.val} : acc_q;
		need    = wide_q ? CountW'(6) : CountW'(4);
		enc     = utf8_encode(dv_upd ? acc_upd : REPLACEMENT);
		case (phase_q)
			PH_ESC: begin
				cnt_n = BurstCntW'(1);
				if (byte_s1 == CH_N) b_n[0] = CH_LF;
				else if (byte_s1 == CH_R) b_n[0] = CH_CR;
				else if (byte_s1 == CH_T) b_n[0] = CH_TAB;
				else if (byte_s1 == CH_X) begin
					if (last_s1) b_n[0] = CH_X;
					else begin
						cnt_n   = '0;
						phase_n = PH_X1;
					end
				end else if (byte_s1 == CH_U) begin
					if (last_s1) b_n[0] = CH_U;
					else begin
						cnt_n   = '0;
						phase_n = PH_USIGN;
					end
				end else b_n[0] = byte_s1;
			end
			PH_X1: begin
				dv_n  = hx.ok;
				acc_n = hx.ok ? AccW'(hx.val) : '0;
				if (last_s1) begin
					b_n[0] = CH_X;
					b_n[1] = byte_s1;
					cnt_n  = BurstCntW'(2);
				end else phase_n = PH_X2;
			end
			PH_X2: begin
				cnt_n = BurstCntW'(1);
				if (dv_q && hx.ok) begin
					if (acc_q[3]) begin
						b_n[0] = LEAD_2B | {6'b0, acc_q[3:2]};
						b_n[1] = CONT_MARK | {2'b0, acc_q[1:0], hx.val};
						cnt_n  = BurstCntW'(2);
					end else b_n[0] = {acc_q[3:0], hx.val};
				end else b_n[0] = CH_X;
			end
			PH_USIGN: begin
				if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
					wide_n = (byte_s1 == CH_MINUS);
					if (last_s1) begin
						b_n[0] = CH_U;
						b_n[1] = byte_s1;
						cnt_n  = BurstCntW'(2);
					end else begin
						phase_n = PH_UDIG;
						dc_n    = '0;
						acc_n   = '0;
						dv_n    = 1'b1;
					end
				end else begin
					// Drop the escape and rerun the byte as plain text
					b_n[0] = CH_U;
					cnt_n  = BurstCntW'(1);
					if (quoted_s1 && esc_en_q && byte_s1 == CH_BSLASH) begin
						if (last_s1) err_n = 1'b1;
						else phase_n = PH_ESC;
					end else begin
						b_n[1] = byte_s1;
						cnt_n  = BurstCntW'(2);
					end
				end
			end
			PH_UDIG: begin
				pend_we = (dc_q < CountW'(PendDepth));
				dv_n    = dv_upd;
				acc_n   = acc_upd;
				dc_n    = dc_inc;
				phase_n = PH_UDIG;
				if (dc_inc >= need) begin
					for (int i = 0; i < 4; i++) b_n[i] = enc.b[i];
					cnt_n   = BurstCntW'(enc.n);
					phase_n = PH_PLAIN;
					dc_n    = '0;
				end else if (last_s1) begin
					// Flush the cut-off escape literally
					b_n[0] = CH_U;
					b_n[1] = wide_q ? CH_MINUS : CH_PLUS;
					for (int i = 0; i < 6; i++) begin
						b_n[BurstIdxW'(i + 2)] = (CountW'(i) == dc_q) ? byte_s1
							: pend_q[CountW'(i)];
					end
					cnt_n   = BurstCntW'(2) + BurstCntW'(dc_inc);
					phase_n = PH_PLAIN;
					dc_n    = '0;
				end
			end
			default: begin
				if (quoted_s1 && esc_en_q && byte_s1 == CH_BSLASH) begin
					if (last_s1) err_n = 1'b1;
					else phase_n = PH_ESC;
				end else begin
					b_n[0] = byte_s1;
					cnt_n  = BurstCntW'(1);
				end
			end
		endcase
		// Scan emitted bytes for quotes
		quote_n = quote_q;
		for (int i = 0; i < BurstMax; i++) begin
			if (BurstCntW'(i) < cnt_n) begin
				if (b_n[i] == CH_SQUOTE) quote_n[0] = 1'b1;
				else if (b_n[i] == CH_DQUOTE) quote_n[1] = 1'b1;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_en_q <= 1'b1;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			esc_en_q <= cfg_ch.data.escape_enable;
		end
	end

	// Input register: load on transfer, drop on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1   <= in_ch.data.in_byte;
			last_s1   <= in_ch.data.in_last;
			quoted_s1 <= in_ch.data.quoted;
		end
	end

	// Escape state: advance on commit, clear at token end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			dc_q    <= '0;
			acc_q   <= '0;
			wide_q  <= 1'b0;
			dv_q    <= 1'b1;
			quote_q <= '0;
		end else if (commit) begin
			if (last_s1) begin
				phase_q <= PH_PLAIN;
				dc_q    <= '0;
				acc_q   <= '0;
				wide_q  <= 1'b0;
				dv_q    <= 1'b1;
				quote_q <= '0;
			end else begin
				phase_q <= phase_n;
				dc_q    <= dc_n;
				acc_q   <= acc_n;
				wide_q  <= wide_n;
				dv_q    <= dv_n;
				quote_q <= quote_n;
			end
		end
	end

	// Collected escape digits
	always_ff @(posedge clk) begin
		if (commit && pend_we) begin
			pend_q[dc_q] <= byte_s1;
		end
	end

	// Burst register: load on commit, advance index per result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (commit) begin
			valid_s2 <= (cnt_n != '0) || last_s1;
			idx_q    <= '0;
		end else if (burst_done) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (out_xfer) begin
			idx_q <= idx_q + BurstIdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < BurstMax; i++) bytes_s2[i] <= b_n[i];
			cnt_s2   <= cnt_n;
			nres_s2  <= (cnt_n == '0) ? BurstCntW'(1) : cnt_n;
			last_s2  <= last_s1;
			err_s2   <= err_n;
			quote_s2 <= quote_n;
		end
	end

	// Result channel
	logic fin;
	assign fin = last_s2 && ({1'b0, idx_q} == nres_s2 - BurstCntW'(1));

	assign out_ch.valid                         = valid_s2;
	assign out_ch.data.out_byte                 = bytes_s2[idx_q];
	assign out_ch.data.out_valid                = (cnt_s2 != '0);
	assign out_ch.data.out_last                 = fin;
	assign out_ch.data.trailing_backslash_error = fin && err_s2;
	assign out_ch.data.seen_single_quote        = fin && quote_s2[0];
	assign out_ch.data.seen_double_quote        = fin && quote_s2[1];
	assign out_ch.data.seen_both_quotes         = fin && quote_s2[0] && quote_s2[1];

`ifndef ASSERT_OFF
	// Drain index stays inside the loaded burst
	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, idx_q} < nres_s2))
		else $error("burst index past result count");

	// An empty burst is only ever the final result of a token
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cnt_s2 == '0) |-> last_s2)
		else $error("empty burst on a non-final byte");

	// Token end returns the escape state to plain text with no quotes seen
	a_token_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_s1) |=> (phase_q == PH_PLAIN && quote_q == '0 && dc_q == '0))
		else $error("token state not cleared at token end");
`endif

endmodule
